/* rtl/rlg_pkg.sv */
// Package for the ROI luma gamma block: widths, register indexes, BT.601
// fixed-point coefficients, queue entry type and the shared arithmetic helpers.
// No dependencies.
`default_nettype none

package rlg_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int COORD_W        = 12;
  localparam int DIM_W          = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_ADDR_W     = 3;
  localparam int PIX_W          = 8;
  localparam int IN_DATA_W      = 64;
  localparam int OUT_DATA_W     = 24;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // all products and sums carried as 25-bit signed, ample for 8-bit colours
  localparam int ACC_W = 25;
  localparam int DS_W  = ACC_W - COEF_FRAC_BITS;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_ROI_LEFT    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROI_TOP     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROI_WIDTH   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ROI_HEIGHT  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WHOLE_IMAGE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FILL_BLUE   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FILL_GREEN  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_FILL_RED    = 3'd7;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  // coefficient = round(k * 2^F / 1000), k in thousandths
  localparam int K_YB  = ((114  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_YG  = ((587  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_YR  = ((299  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_CR  = ((713  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_CB  = ((564  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_BCB = ((1773 << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_GCR = ((714  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_GCB = ((344  << COEF_FRAC_BITS) + 500) / 1000;
  localparam int K_RCR = ((1403 << COEF_FRAC_BITS) + 500) / 1000;

  localparam logic signed [ACC_W-1:0] C_YB  = ACC_W'(K_YB);
  localparam logic signed [ACC_W-1:0] C_YG  = ACC_W'(K_YG);
  localparam logic signed [ACC_W-1:0] C_YR  = ACC_W'(K_YR);
  localparam logic signed [ACC_W-1:0] C_CR  = ACC_W'(K_CR);
  localparam logic signed [ACC_W-1:0] C_CB  = ACC_W'(K_CB);
  localparam logic signed [ACC_W-1:0] C_BCB = ACC_W'(K_BCB);
  localparam logic signed [ACC_W-1:0] C_GCR = ACC_W'(K_GCR);
  localparam logic signed [ACC_W-1:0] C_GCB = ACC_W'(K_GCB);
  localparam logic signed [ACC_W-1:0] C_RCR = ACC_W'(K_RCR);
  localparam logic signed [ACC_W-1:0] C_HALF  = ACC_W'(1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] C_DELTA = ACC_W'(128 << COEF_FRAC_BITS);

  // queue entry: for a table write c0 is the index and c1 the value
  typedef struct packed {
    logic             wr;
    logic             gamma;
    logic [PIX_W-1:0] c0;
    logic [PIX_W-1:0] c1;
    logic [PIX_W-1:0] c2;
  } q_entry_t;

  // round half up then floor: arithmetic shift keeps negative values right
  function automatic logic signed [DS_W-1:0] descale(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + C_HALF;
    return t[ACC_W-1:COEF_FRAC_BITS];
  endfunction

  function automatic logic [PIX_W-1:0] sat8(logic signed [DS_W:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > (DS_W+1)'(255)) begin
      return 8'hff;
    end
    return v[PIX_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] uext(logic [PIX_W-1:0] v);
    return {{(ACC_W-PIX_W){1'b0}}, v};
  endfunction

endpackage : rlg_pkg

`default_nettype wire

/* rtl/roi_luma_gamma_lut_top.sv */
// Path: an accepted item waits in the queue, then passes stages 1 to 6 of the back
// pipeline; stage 6 is the output register.
// Throughput: one item per cycle; table writes give no result.
// Rate is set by the back pipeline, which advances whenever the output is free.
// Reset (rst_n, synchronous, active low) restores the configuration registers
// and empties the queue and pipeline; gamma table contents are not cleared.
`default_nettype none

module roi_luma_gamma_lut_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rlg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rlg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pixel_x, pixel_y, in_blue, in_green, in_red, table_index, table_value
  input  logic [rlg_pkg::IN_DATA_W-1:0]      in_tdata,
  // operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_blue, out_green, out_red
  output logic [rlg_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import rlg_pkg::*;

  q_entry_t q_din, q_head;
  logic     q_push, q_full, q_pop, q_valid;

  rlg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  rlg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid)
  );

  rlg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule : roi_luma_gamma_lut_top

`default_nettype wire

/* rtl/rlg_front.sv */
// Front end: configuration registers, item intake and classification
// (table write, gamma pixel or fill pixel). Uses rlg_pkg.
`default_nettype none

module rlg_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rlg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rlg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rlg_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tuser,
  input  logic                               q_full,
  output logic                               q_push,
  output rlg_pkg::q_entry_t                  q_din
);
  import rlg_pkg::*;

  logic [COORD_W-1:0] roi_left_r, roi_top_r;
  logic [DIM_W-1:0]   roi_width_r, roi_height_r;
  logic               whole_image_r;
  logic [PIX_W-1:0]   fill_blue_r, fill_green_r, fill_red_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_left_r    <= '0;
      roi_top_r     <= '0;
      roi_width_r   <= DIM_W'(4096);
      roi_height_r  <= DIM_W'(4096);
      whole_image_r <= 1'b1;
      fill_blue_r   <= '0;
      fill_green_r  <= '0;
      fill_red_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROI_LEFT:    roi_left_r    <= cfg_wdata[COORD_W-1:0];
        REG_ROI_TOP:     roi_top_r     <= cfg_wdata[COORD_W-1:0];
        REG_ROI_WIDTH:   roi_width_r   <= cfg_wdata[DIM_W-1:0];
        REG_ROI_HEIGHT:  roi_height_r  <= cfg_wdata[DIM_W-1:0];
        REG_WHOLE_IMAGE: whole_image_r <= cfg_wdata[0];
        REG_FILL_BLUE:   fill_blue_r   <= cfg_wdata[PIX_W-1:0];
        REG_FILL_GREEN:  fill_green_r  <= cfg_wdata[PIX_W-1:0];
        REG_FILL_RED:    fill_red_r    <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COORD_W-1:0] px, py;
  logic [PIX_W-1:0]   pb, pg, pr, tidx, tval;
  logic [DIM_W:0]     x_end, y_end;
  logic               in_roi, gamma;

  assign px   = in_tdata[11:0];
  assign py   = in_tdata[23:12];
  assign pb   = in_tdata[31:24];
  assign pg   = in_tdata[39:32];
  assign pr   = in_tdata[47:40];
  assign tidx = in_tdata[55:48];
  assign tval = in_tdata[63:56];

  // end sums are carried in DIM_W+1 bits, so they never wrap and need no clip to the frame
  assign x_end  = {2'b00, roi_left_r} + {1'b0, roi_width_r};
  assign y_end  = {2'b00, roi_top_r} + {1'b0, roi_height_r};
  assign in_roi = (px >= roi_left_r) && ({2'b00, px} < x_end) &&
                  (py >= roi_top_r) && ({2'b00, py} < y_end);
  assign gamma  = whole_image_r | in_roi;

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

  always_comb begin
    q_din.wr    = (in_tuser == OP_TABLE);
    q_din.gamma = gamma;
    if (in_tuser == OP_TABLE) begin
      q_din.c0 = tidx;
      q_din.c1 = tval;
      q_din.c2 = '0;
    end else if (gamma) begin
      q_din.c0 = pb;
      q_din.c1 = pg;
      q_din.c2 = pr;
    end else begin
      q_din.c0 = fill_blue_r;
      q_din.c1 = fill_green_r;
      q_din.c2 = fill_red_r;
    end
  end

endmodule : rlg_front

`default_nettype wire

/* rtl/rlg_fifo.sv */
// Short queue of classified items between front and back end.
// Uses rlg_pkg for the entry type and depth.
`default_nettype none

module rlg_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rlg_pkg::q_entry_t din,
  output logic              full,
  input  logic              pop,
  output rlg_pkg::q_entry_t head,
  output logic              not_empty
);
  import rlg_pkg::*;

  q_entry_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_r, rptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rptr_r];
  assign do_pop    = pop & not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule : rlg_fifo

`default_nettype wire

/* rtl/rlg_back.sv */
// Back end: six-stage colour pipeline (BGR->YCrCb, gamma lookup, YCrCb->BGR)
// with the gamma table memory and the output register. Uses rlg_pkg.
`default_nettype none

module rlg_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rlg_pkg::q_entry_t               q_head,
  input  logic                            q_valid,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rlg_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import rlg_pkg::*;

  logic en;

  // whole pipe moves together; the output register is the last stage
  assign en    = ~out_tvalid | out_tready;
  assign q_pop = en & q_valid;

  // stage 1: luma products
  logic                    v1_r, wr1_r, gam1_r;
  logic [PIX_W-1:0]        b1_r, g1_r, r1_r;
  logic signed [ACC_W-1:0] yacc1_r;
  // stage 2: luma
  logic                    v2_r, wr2_r, gam2_r;
  logic [PIX_W-1:0]        b2_r, g2_r, r2_r, y2_r;
  // stage 3: chroma products, table read/write
  logic                    v3_r, gam3_r;
  logic [PIX_W-1:0]        y3_r, memq_r;
  logic signed [ACC_W-1:0] cracc3_r, cbacc3_r;
  // stage 4: chroma, gamma-mapped luma
  logic                    v4_r;
  logic [PIX_W-1:0]        y4_r, cr4_r, cb4_r;
  // stage 5: inverse products
  logic                    v5_r;
  logic [PIX_W-1:0]        y5_r;
  logic signed [ACC_W-1:0] accb5_r, accg5_r, accr5_r;
  // stage 6: output
  logic [PIX_W-1:0]        ob_r, og_r, or_r;

  logic [PIX_W-1:0] gamma_mem [256];

  logic signed [DS_W-1:0]  ds_y, ds_cr, ds_cb, ds_b, ds_g, ds_r;
  logic signed [ACC_W-1:0] dry, dby, dcr, dcb;

  assign ds_y  = descale(yacc1_r);
  assign ds_cr = descale(cracc3_r);
  assign ds_cb = descale(cbacc3_r);
  assign ds_b  = descale(accb5_r);
  assign ds_g  = descale(accg5_r);
  assign ds_r  = descale(accr5_r);
  assign dry   = uext(r2_r) - uext(y2_r);
  assign dby   = uext(b2_r) - uext(y2_r);
  assign dcr   = uext(cr4_r) - ACC_W'(128);
  assign dcb   = uext(cb4_r) - ACC_W'(128);

  // table items are in order with pixels: a write here is seen by any later read
  always_ff @(posedge clk) begin
    if (en) begin
      if (v2_r && wr2_r) begin
        gamma_mem[b2_r] <= g2_r;
      end
      memq_r <= gamma_mem[y2_r];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr1_r   <= q_head.wr;
      gam1_r  <= q_head.gamma;
      b1_r    <= q_head.c0;
      g1_r    <= q_head.c1;
      r1_r    <= q_head.c2;
      yacc1_r <= uext(q_head.c0) * C_YB + uext(q_head.c1) * C_YG
               + uext(q_head.c2) * C_YR;

      wr2_r  <= wr1_r;
      gam2_r <= gam1_r;
      b2_r   <= b1_r;
      g2_r   <= g1_r;
      r2_r   <= r1_r;
      y2_r   <= sat8({ds_y[DS_W-1], ds_y});

      gam3_r   <= gam2_r;
      y3_r     <= y2_r;
      cracc3_r <= dry * C_CR + C_DELTA;
      cbacc3_r <= dby * C_CB + C_DELTA;

      y4_r  <= gam3_r ? memq_r : y3_r;
      cr4_r <= sat8({ds_cr[DS_W-1], ds_cr});
      cb4_r <= sat8({ds_cb[DS_W-1], ds_cb});

      y5_r    <= y4_r;
      accb5_r <= dcb * C_BCB;
      accg5_r <= -(dcr * C_GCR) - dcb * C_GCB;
      accr5_r <= dcr * C_RCR;

      ob_r <= sat8({4'b0000, y5_r} + {ds_b[DS_W-1], ds_b});
      og_r <= sat8({4'b0000, y5_r} + {ds_g[DS_W-1], ds_g});
      or_r <= sat8({4'b0000, y5_r} + {ds_r[DS_W-1], ds_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      v1_r       <= q_valid;
      v2_r       <= v1_r;
      v3_r       <= v2_r & ~wr2_r;   // table writes retire here
      v4_r       <= v3_r;
      v5_r       <= v4_r;
      out_tvalid <= v5_r;
    end
  end

  assign out_tdata = {or_r, og_r, ob_r};

endmodule : rlg_back

`default_nettype wire
